/* design/stb_pkg.sv */
// Shared types, codes and defaults for the soft timer bank.
package stb_pkg;

  localparam int NUM_TIMERS_DEF  = 16;
  localparam int DELAY_WIDTH_DEF = 32;

  localparam int CMD_W   = 3;
  localparam int IDX_W   = 4;
  localparam int REP_W   = 17;
  localparam int DLY_W   = 32;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = 5;

  localparam int MAX_RESULTS = 16;
  localparam int COUNT_SAT   = 31;
  localparam int QUEUE_DEPTH = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CREATE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_START  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_STOP   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd4;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd5;

  // Result kinds
  localparam logic [KIND_W-1:0] RK_FIRED   = 2'd0;
  localparam logic [KIND_W-1:0] RK_CREATED = 2'd1;
  localparam logic [KIND_W-1:0] RK_COUNTS  = 2'd2;
  localparam logic [KIND_W-1:0] RK_ACK     = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_ALLOC = 2'd2;

  // Slot phases
  localparam logic [1:0] PH_UNUSED   = 2'd0;
  localparam logic [1:0] PH_RUNNING  = 2'd1;
  localparam logic [1:0] PH_COMPLETE = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic [IDX_W-1:0]        idx;
    logic                    kind;
    logic signed [REP_W-1:0] rep;
    logic [DLY_W-1:0]        delay;
  } cmd_entry_t;

  typedef struct packed {
    logic       valid;
    cmd_entry_t entry;
  } push_t;

endpackage

/* design/stb_if.sv */
// Handshake channel interfaces for the command and result streams.
interface stb_in_if;
  logic                            valid;
  logic                            ready;
  logic [stb_pkg::CMD_W-1:0]       command;
  logic [stb_pkg::IDX_W-1:0]       timer_index;
  logic                            timer_kind;
  logic signed [stb_pkg::REP_W-1:0] repeat_count;
  logic [stb_pkg::DLY_W-1:0]       delay_ticks;

  modport source (output valid, command, timer_index, timer_kind, repeat_count,
                  delay_ticks, input ready);
  modport sink (input valid, command, timer_index, timer_kind, repeat_count,
                delay_ticks, output ready);
endinterface

interface stb_out_if;
  logic                         valid;
  logic                         ready;
  logic [stb_pkg::KIND_W-1:0]   result_kind;
  logic [stb_pkg::IDX_W-1:0]    slot;
  logic [stb_pkg::STAT_W-1:0]   status;
  logic [stb_pkg::CNT_W-1:0]    unused_count;
  logic [stb_pkg::CNT_W-1:0]    running_count;
  logic [stb_pkg::CNT_W-1:0]    complete_count;
  logic                         last_of_run;

  modport source (output valid, result_kind, slot, status, unused_count, running_count,
                  complete_count, last_of_run, input ready);
  modport sink (input valid, result_kind, slot, status, unused_count, running_count,
                complete_count, last_of_run, output ready);
endinterface

/* design/stb_front.sv */
// Front end: accept command transactions, drop unused codes, push the rest.
module stb_front (
  stb_in_if.sink         in_ch,
  input  logic           q_full,
  output stb_pkg::push_t push
);

  logic cmd_known;

  assign cmd_known  = (in_ch.command <= stb_pkg::CMD_QUERY);
  assign in_ch.ready = !q_full;

  always_comb begin
    push.valid       = in_ch.valid && !q_full && cmd_known;
    push.entry.cmd   = in_ch.command;
    push.entry.idx   = in_ch.timer_index;
    push.entry.kind  = in_ch.timer_kind;
    push.entry.rep   = in_ch.repeat_count;
    push.entry.delay = in_ch.delay_ticks;
  end

endmodule

/* design/stb_cmd_queue.sv */
// Short command queue between the front end and the timer engine.
module stb_cmd_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  stb_pkg::push_t          push,
  output logic                    q_full,
  output logic                    q_valid,
  output stb_pkg::cmd_entry_t     q_entry,
  input  logic                    q_pop
);

  localparam int AW = (stb_pkg::QUEUE_DEPTH > 1) ? $clog2(stb_pkg::QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(stb_pkg::QUEUE_DEPTH + 1);

  stb_pkg::cmd_entry_t ent_r [stb_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic          do_pop;

  assign q_full  = (cnt_r == NW'(stb_pkg::QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_entry = ent_r[rd_r];
  assign do_pop  = q_pop && q_valid;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push.valid) begin
      wr_nxt = (wr_r == AW'(stb_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == AW'(stb_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (push.valid && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push.valid && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      ent_r[wr_r] <= push.entry;
    end
  end

endmodule

/* design/stb_engine.sv */
// Timer engine: slot table, sweeps for tick and query, and the result register.
module stb_engine #(
  parameter int NUM_TIMERS  = stb_pkg::NUM_TIMERS_DEF,
  parameter int DELAY_WIDTH = stb_pkg::DELAY_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  stb_pkg::cmd_entry_t q_entry,
  output logic                q_pop,
  stb_out_if.source           out_ch
);

  localparam int SW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int PW = $clog2(NUM_TIMERS + 1);
  localparam int XW = (PW > stb_pkg::IDX_W) ? PW : stb_pkg::IDX_W;
  localparam int QW = (PW > stb_pkg::CNT_W) ? PW : stb_pkg::CNT_W;
  localparam int RW = stb_pkg::REP_W;
  localparam int DW = DELAY_WIDTH;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SLOT  = 3'd1;
  localparam logic [2:0] S_RMW   = 3'd2;
  localparam logic [2:0] S_FIND  = 3'd3;
  localparam logic [2:0] S_SWEEP = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;

  // Slot table
  logic [1:0]          mem_phase [NUM_TIMERS];
  logic                mem_per   [NUM_TIMERS];
  logic signed [RW-1:0] mem_rep  [NUM_TIMERS];
  logic [DW-1:0]       mem_dly   [NUM_TIMERS];
  logic [DW-1:0]       mem_rem   [NUM_TIMERS];

  logic [1:0]           rd_phase;
  logic                 rd_per;
  logic signed [RW-1:0] rd_rep;
  logic [DW-1:0]        rd_dly;
  logic [DW-1:0]        rd_rem;

  logic                 rd_en, mem_we;
  logic [SW-1:0]        rd_addr, mem_wa;
  logic [1:0]           wd_phase;
  logic                 wd_per;
  logic signed [RW-1:0] wd_rep;
  logic [DW-1:0]        wd_dly, wd_rem;

  // Control
  logic [2:0]                state_r, state_nxt;
  stb_pkg::cmd_entry_t       cmd_r, cmd_nxt;
  logic [PW-1:0]             ptr_r, ptr_nxt;
  logic                      proc_v_r, proc_v_nxt;
  logic [SW-1:0]             proc_idx_r, proc_idx_nxt;
  logic [4:0]                nfire_r, nfire_nxt;
  logic                      pend_v_r, pend_v_nxt;
  logic [stb_pkg::IDX_W-1:0] pend_slot_r, pend_slot_nxt;
  logic [PW-1:0]             cu_r, cu_nxt, cr_r, cr_nxt, cc_r, cc_nxt;
  logic [NUM_TIMERS-1:0]     alloc_r, alloc_nxt;

  // Result register
  logic                       out_v_r, out_v_nxt;
  logic [stb_pkg::KIND_W-1:0] out_kind_r;
  logic [stb_pkg::IDX_W-1:0]  out_slot_r;
  logic [stb_pkg::STAT_W-1:0] out_stat_r;
  logic [stb_pkg::CNT_W-1:0]  out_nu_r, out_nr_r, out_nc_r;
  logic                       out_last_r;

  logic                       emit, emit_ok;
  logic [stb_pkg::KIND_W-1:0] e_kind;
  logic [stb_pkg::IDX_W-1:0]  e_slot;
  logic [stb_pkg::STAT_W-1:0] e_stat;
  logic [stb_pkg::CNT_W-1:0]  e_nu, e_nr, e_nc;
  logic                       e_last;

  // Decode helpers
  logic [XW-1:0]  idx_x, ptr_x, proc_x;
  logic [SW-1:0]  cmd_addr, find_addr;
  logic           in_range, slot_ok;
  logic [DW-1:0]  new_dly, rem_dec;
  logic           run, fire, keep, stall;
  logic [1:0]     t_phase;
  logic signed [RW-1:0] t_rep;
  logic [DW-1:0]  t_rem;

  function automatic logic [stb_pkg::CNT_W-1:0] sat_cnt(input logic [PW-1:0] c);
    logic [QW-1:0] cx;
    cx = QW'(c);
    return (cx > QW'(stb_pkg::COUNT_SAT)) ? stb_pkg::CNT_W'(stb_pkg::COUNT_SAT)
                                          : cx[stb_pkg::CNT_W-1:0];
  endfunction

  assign idx_x     = XW'(cmd_r.idx);
  assign ptr_x     = XW'(ptr_r);
  assign proc_x    = XW'(proc_idx_r);
  assign cmd_addr  = idx_x[SW-1:0];
  assign find_addr = ptr_r[SW-1:0];
  assign in_range  = (idx_x < XW'(NUM_TIMERS));
  assign slot_ok   = in_range && alloc_r[cmd_addr];
  assign new_dly   = (DW'(cmd_r.delay) == '0) ? DW'(1) : DW'(cmd_r.delay);
  assign emit_ok   = !out_v_r || out_ch.ready;

  // Tick countdown for the slot in the processing stage
  always_comb begin
    run     = proc_v_r && (cmd_r.cmd == stb_pkg::CMD_TICK) && alloc_r[proc_idx_r]
              && (rd_phase == stb_pkg::PH_RUNNING);
    rem_dec = rd_rem - DW'(1);
    fire    = run && (rem_dec == '0);
    keep    = fire && (nfire_r < 5'(stb_pkg::MAX_RESULTS));
    stall   = keep && pend_v_r && !emit_ok;
    t_phase = rd_phase;
    t_rep   = rd_rep;
    t_rem   = rem_dec;
    if (fire) begin
      if (!rd_per) begin
        t_phase = stb_pkg::PH_COMPLETE;
      end else if (rd_rep < 0) begin
        t_rem = rd_dly;
      end else if (rd_rep > 0) begin
        t_rep = rd_rep - RW'(1);
        t_rem = rd_dly;
      end else begin
        t_phase = stb_pkg::PH_COMPLETE;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    ptr_nxt       = ptr_r;
    proc_v_nxt    = proc_v_r;
    proc_idx_nxt  = proc_idx_r;
    nfire_nxt     = nfire_r;
    pend_v_nxt    = pend_v_r;
    pend_slot_nxt = pend_slot_r;
    cu_nxt        = cu_r;
    cr_nxt        = cr_r;
    cc_nxt        = cc_r;
    alloc_nxt     = alloc_r;
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = find_addr;
    mem_we        = 1'b0;
    mem_wa        = proc_idx_r;
    wd_phase      = t_phase;
    wd_per        = rd_per;
    wd_rep        = t_rep;
    wd_dly        = rd_dly;
    wd_rem        = t_rem;
    emit          = 1'b0;
    e_kind        = stb_pkg::RK_FIRED;
    e_slot        = '0;
    e_stat        = stb_pkg::ST_OK;
    e_nu          = '0;
    e_nr          = '0;
    e_nc          = '0;
    e_last        = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        q_pop = q_valid;
        if (q_valid) begin
          cmd_nxt    = q_entry;
          ptr_nxt    = '0;
          proc_v_nxt = 1'b0;
          nfire_nxt  = '0;
          pend_v_nxt = 1'b0;
          cu_nxt     = '0;
          cr_nxt     = '0;
          cc_nxt     = '0;
          unique case (q_entry.cmd)
            stb_pkg::CMD_TICK, stb_pkg::CMD_QUERY: state_nxt = S_SWEEP;
            stb_pkg::CMD_CREATE:                   state_nxt = S_FIND;
            default:                               state_nxt = S_SLOT;
          endcase
        end
      end

      S_SLOT: begin
        if (!slot_ok || cmd_r.cmd == stb_pkg::CMD_DELETE) begin
          if (emit_ok) begin
            emit   = 1'b1;
            e_kind = stb_pkg::RK_ACK;
            e_slot = cmd_r.idx;
            e_stat = slot_ok ? stb_pkg::ST_OK : stb_pkg::ST_NOT_ALLOC;
            if (slot_ok) begin
              alloc_nxt[cmd_addr] = 1'b0;
            end
            state_nxt = S_IDLE;
          end
        end else begin
          // Fetch the slot word for the phase update
          rd_en     = 1'b1;
          rd_addr   = cmd_addr;
          state_nxt = S_RMW;
        end
      end

      S_RMW: begin
        if (emit_ok) begin
          mem_we   = 1'b1;
          mem_wa   = cmd_addr;
          wd_phase = (cmd_r.cmd == stb_pkg::CMD_START) ? stb_pkg::PH_RUNNING
                                                       : stb_pkg::PH_COMPLETE;
          wd_rep   = rd_rep;
          wd_rem   = rd_rem;
          emit     = 1'b1;
          e_kind   = stb_pkg::RK_ACK;
          e_slot   = cmd_r.idx;
          state_nxt = S_IDLE;
        end
      end

      S_FIND: begin
        if (!alloc_r[find_addr]) begin
          if (emit_ok) begin
            mem_we   = 1'b1;
            mem_wa   = find_addr;
            wd_phase = stb_pkg::PH_UNUSED;
            wd_per   = cmd_r.kind;
            wd_rep   = cmd_r.rep;
            wd_dly   = new_dly;
            wd_rem   = new_dly;
            alloc_nxt[find_addr] = 1'b1;
            emit      = 1'b1;
            e_kind    = stb_pkg::RK_CREATED;
            e_slot    = ptr_x[stb_pkg::IDX_W-1:0];
            state_nxt = S_IDLE;
          end
        end else if (ptr_r == PW'(NUM_TIMERS - 1)) begin
          if (emit_ok) begin
            emit      = 1'b1;
            e_kind    = stb_pkg::RK_ACK;
            e_stat    = stb_pkg::ST_FULL;
            state_nxt = S_IDLE;
          end
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end

      S_SWEEP: begin
        // Read stage: fetch the next slot unless the processing stage holds
        if (!stall) begin
          if (ptr_r != PW'(NUM_TIMERS)) begin
            rd_en        = 1'b1;
            rd_addr      = find_addr;
            proc_v_nxt   = 1'b1;
            proc_idx_nxt = find_addr;
            ptr_nxt      = ptr_r + 1'b1;
          end else begin
            proc_v_nxt = 1'b0;
          end
        end
        // Processing stage
        if (run && !stall) begin
          mem_we = 1'b1;
          if (keep) begin
            if (pend_v_r) begin
              emit   = 1'b1;
              e_kind = stb_pkg::RK_FIRED;
              e_slot = pend_slot_r;
              e_last = 1'b0;
            end
            pend_v_nxt    = 1'b1;
            pend_slot_nxt = proc_x[stb_pkg::IDX_W-1:0];
            nfire_nxt     = nfire_r + 1'b1;
          end
        end
        if (proc_v_r && cmd_r.cmd == stb_pkg::CMD_QUERY && alloc_r[proc_idx_r]) begin
          if (rd_phase == stb_pkg::PH_UNUSED) begin
            cu_nxt = cu_r + 1'b1;
          end else if (rd_phase == stb_pkg::PH_RUNNING) begin
            cr_nxt = cr_r + 1'b1;
          end else if (rd_phase == stb_pkg::PH_COMPLETE) begin
            cc_nxt = cc_r + 1'b1;
          end
        end
        if (ptr_r == PW'(NUM_TIMERS) && !proc_v_r) begin
          if (cmd_r.cmd == stb_pkg::CMD_TICK) begin
            state_nxt = S_FLUSH;
          end else if (emit_ok) begin
            emit      = 1'b1;
            e_kind    = stb_pkg::RK_COUNTS;
            e_nu      = sat_cnt(cu_r);
            e_nr      = sat_cnt(cr_r);
            e_nc      = sat_cnt(cc_r);
            state_nxt = S_IDLE;
          end
        end
      end

      S_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (emit_ok) begin
          emit       = 1'b1;
          e_kind     = stb_pkg::RK_FIRED;
          e_slot     = pend_slot_r;
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    out_v_nxt = emit ? 1'b1 : (out_ch.ready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ptr_r    <= '0;
      proc_v_r <= 1'b0;
      nfire_r  <= '0;
      pend_v_r <= 1'b0;
      alloc_r  <= '0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ptr_r    <= ptr_nxt;
      proc_v_r <= proc_v_nxt;
      nfire_r  <= nfire_nxt;
      pend_v_r <= pend_v_nxt;
      alloc_r  <= alloc_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    proc_idx_r  <= proc_idx_nxt;
    pend_slot_r <= pend_slot_nxt;
    cu_r        <= cu_nxt;
    cr_r        <= cr_nxt;
    cc_r        <= cc_nxt;
    if (emit) begin
      out_kind_r <= e_kind;
      out_slot_r <= e_slot;
      out_stat_r <= e_stat;
      out_nu_r   <= e_nu;
      out_nr_r   <= e_nr;
      out_nc_r   <= e_nc;
      out_last_r <= e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_phase[mem_wa] <= wd_phase;
      mem_per[mem_wa]   <= wd_per;
      mem_rep[mem_wa]   <= wd_rep;
      mem_dly[mem_wa]   <= wd_dly;
      mem_rem[mem_wa]   <= wd_rem;
    end
    if (rd_en) begin
      rd_phase <= mem_phase[rd_addr];
      rd_per   <= mem_per[rd_addr];
      rd_rep   <= mem_rep[rd_addr];
      rd_dly   <= mem_dly[rd_addr];
      rd_rem   <= mem_rem[rd_addr];
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.result_kind    = out_kind_r;
  assign out_ch.slot           = out_slot_r;
  assign out_ch.status         = out_stat_r;
  assign out_ch.unused_count   = out_nu_r;
  assign out_ch.running_count  = out_nr_r;
  assign out_ch.complete_count = out_nc_r;
  assign out_ch.last_of_run    = out_last_r;

endmodule

/* design/soft_timer_bank.sv */
// Top level of the soft timer bank: front end, command queue and timer engine.
//
// Usage: commands arrive as transactions on in_ch (tick, create, start, stop,
// delete, query); results leave as transactions on out_ch, each carrying
// last_of_run on the final result caused by one command. Commands 6 and 7 are
// accepted and dropped. A tick with no expiring slot returns nothing.
//
// Timing: a command is popped from the two-entry queue while the engine is
// idle. A tick or query sweeps the slot table through one memory read port,
// one slot per cycle unless a held tick result stalls the sweep; a tick ends
// with a closing flush step. Create scans the allocation bits one slot per
// cycle. Start and stop read and write back the slot word; delete and errors
// emit their result without reading it. Results leave from the output
// register.
//
// Reset: all slots free, queue empty, no result pending. The slot table needs
// no clearing pass since the allocation bits gate every read.
//
// Backpressure: while out_ch stalls, steps that emit a result are held; the
// queue keeps accepting until both entries are full, then in_ch.ready drops.
module soft_timer_bank #(
  parameter int NUM_TIMERS  = stb_pkg::NUM_TIMERS_DEF,
  parameter int DELAY_WIDTH = stb_pkg::DELAY_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  stb_in_if.sink    in_ch,
  stb_out_if.source out_ch
);

  stb_pkg::push_t      push;
  stb_pkg::cmd_entry_t q_entry;
  logic                q_full;
  logic                q_valid;
  logic                q_pop;

  // Decode and drop unknown codes
  stb_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push)
  );

  // Decouple the input side from long sweeps
  stb_cmd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .q_full  (q_full),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .q_pop   (q_pop)
  );

  // Execute commands against the slot table
  stb_engine #(
    .NUM_TIMERS  (NUM_TIMERS),
    .DELAY_WIDTH (DELAY_WIDTH)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
